>>> hdl/tbar_pkg.sv
// tbar_pkg: shared widths, register indexes and defaults for the time-bin
// average resampler. No dependencies.
package tbar_pkg;

    localparam int TIME_W     = 52;
    localparam int SAMPLE_W   = 16;
    localparam int WIDTH_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 52;

    // stream payload widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;

    // defaults
    localparam int MAX_PER_BIN_DEF        = 4096;
    localparam int MAX_BINS_PER_INPUT_DEF = 64;
    localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 24'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = 2'd2;

endpackage

>>> hdl/time_bin_average_resampler.sv
// Time-bin average resampler: timestamped samples in, one averaged result per
// closed time bin out; bins jumped over past the bin limit give no result and
// bins_dropped flags the jump. Depends on tbar_pkg. A new sample is accepted only
// once the previous one is fully handled, including its closed bins, and result
// stalls hold off the input. The shared serial divider forms the mean when the first
// closed bin holds samples and locates the target bin on a jump past the bin limit.
// Reset (aresetn, synchronous, active low) loads register defaults, puts the
// grid at time 0 with an empty bin and drops any pending result.
module time_bin_average_resampler #(
    parameter int MAX_PER_BIN        = tbar_pkg::MAX_PER_BIN_DEF,
    parameter int MAX_BINS_PER_INPUT = tbar_pkg::MAX_BINS_PER_INPUT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [tbar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbar_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] sample_value, [67:16] sample_time, [71:68] zero
    input  logic [tbar_pkg::S_TDATA_W-1:0]   s_tdata,
    // bin results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [51:0] bin_centre_time, [67:52] bin_average, [71:68] zero
    output logic [tbar_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,   // last_of_run
    // [0] bin_empty, [1] bins_dropped, [2] grid_done
    output logic [tbar_pkg::M_TUSER_W-1:0]   m_tuser
);
    import tbar_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PER_BIN + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_PER_BIN) + 1;
    localparam int NBIN_W = $clog2(MAX_BINS_PER_INPUT + 1);
    localparam int DVR_W  = (WIDTH_W > CNT_W) ? WIDTH_W : CNT_W;
    localparam int DCNT_W = $clog2(TIME_W + 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_TEST    = 8'b0000_0010,
        ST_OPEN    = 8'b0000_0100,
        ST_DIV     = 8'b0000_1000,
        ST_STEP    = 8'b0001_0000,
        ST_CHECK   = 8'b0010_0000,
        ST_SKIPCHK = 8'b0100_0000,
        ST_SEND    = 8'b1000_0000
    } state_t;

    // IDLE sub-phase: PH_ACC adds the accepted sample to the open bin unless the bin is full or the grid is finished
    typedef enum logic [1:0] {
        PH_RUN = 2'b01,
        PH_ACC = 2'b10
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // configuration and grid state
    logic [WIDTH_W-1:0]      width_reg;
    logic [TIME_W-1:0]       end_reg;
    logic [TIME_W:0]         cur_reg;     // one spare bit: may step past 2^52
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    fin_reg;

    // current sample and run
    logic signed [SAMPLE_W-1:0] v_reg;
    logic [TIME_W-1:0]       t_reg;
    logic [TIME_W-1:0]       diff_reg;
    logic [NBIN_W-1:0]       nbin_reg;

    // staged result
    logic [TIME_W-1:0]       res_centre_reg;
    logic [SAMPLE_W-1:0]     res_avg_reg;
    logic                    res_empty_reg;
    logic                    res_dropped_reg;
    logic                    res_last_reg;
    logic                    res_done_reg;

    // shared restoring divider
    logic [TIME_W-1:0]       dvd_reg;
    logic [DVR_W-1:0]        rem_reg;
    logic [DVR_W-1:0]        dvr_reg;
    logic [DCNT_W-1:0]       dcnt_reg;
    logic                    neg_reg;
    logic                    skip_mode_reg;

    // combinational helpers
    logic [WIDTH_W-1:0]      w_eff;
    logic [TIME_W+1:0]       diff_full;
    logic                    cur_ge_end;
    logic                    diff_ge_w;
    logic                    more_bins;
    logic                    cnt_zero;
    logic                    div_done;
    logic                    out_free;
    logic                    at_bin_limit;
    logic [WIDTH_W:0]        half_w;
    logic [SUM_W-1:0]        sum_abs;
    logic [DVR_W:0]          div_shift;
    logic [DVR_W+1:0]        div_trial;
    logic [SUM_W-1:0]        quot;

    assign w_eff        = (width_reg == '0) ? WIDTH_W'(1) : width_reg;
    assign diff_full    = {2'b00, t_reg} - {1'b0, cur_reg};
    assign cur_ge_end   = cur_reg >= {1'b0, end_reg};
    assign diff_ge_w    = diff_reg >= TIME_W'(w_eff);
    assign more_bins    = diff_full[TIME_W-1:0] >= TIME_W'(w_eff);
    assign cnt_zero     = cnt_reg == '0;
    assign div_done     = dcnt_reg == '0;
    assign out_free     = !m_tvalid || m_tready;
    assign at_bin_limit = nbin_reg == NBIN_W'(MAX_BINS_PER_INPUT);
    assign half_w       = ({1'b0, w_eff} + (WIDTH_W+1)'(1)) >> 1;
    assign sum_abs      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_shift    = {rem_reg, dvd_reg[TIME_W-1]};
    assign div_trial    = {1'b0, div_shift} - {2'b00, dvr_reg};
    assign quot         = dvd_reg[SUM_W-1:0];

    assign s_tready = (state_reg == ST_IDLE) && (phase_reg == PH_RUN);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (phase_reg == PH_ACC) begin
                    phase_next = PH_RUN;
                end else if (s_tvalid) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                // finished, grid past end, or sample before the open bin
                if (fin_reg || cur_ge_end || diff_full[TIME_W+1]) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN: begin
                if (diff_ge_w) begin
                    state_next = cnt_zero ? ST_STEP : ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                    phase_next = PH_ACC;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = skip_mode_reg ? ST_SKIPCHK : ST_STEP;
                end
            end
            ST_STEP: state_next = ST_CHECK;
            ST_CHECK: begin
                if (!cur_ge_end && more_bins && at_bin_limit) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_SEND;
                end
            end
            ST_SKIPCHK: state_next = ST_SEND;
            ST_SEND: begin
                if (out_free) begin
                    if (res_last_reg) begin
                        state_next = ST_IDLE;
                        phase_next = PH_ACC;
                    end else begin
                        state_next = ST_OPEN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                phase_next = PH_RUN;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_RUN;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // configuration, grid and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= BIN_WIDTH_RESET;
            end_reg   <= '0;
            cur_reg   <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            fin_reg   <= 1'b0;
            m_tvalid  <= 1'b0;
        end else begin
            if (state_reg == ST_SEND && out_free) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_BIN_WIDTH: width_reg <= cfg_wdata[WIDTH_W-1:0];
                    REG_START_TIME: begin
                        cur_reg <= {1'b0, cfg_wdata[TIME_W-1:0]};
                        sum_reg <= '0;
                        cnt_reg <= '0;
                        fin_reg <= 1'b0;
                    end
                    REG_END_TIME: end_reg <= cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (phase_reg == PH_ACC && !fin_reg
                        && cnt_reg < CNT_W'(MAX_PER_BIN)) begin
                        sum_reg <= sum_reg + SUM_W'(v_reg);
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DIV: begin
                    if (div_done && skip_mode_reg) begin
                        // jump to the bin that holds the sample
                        cur_reg <= {1'b0, t_reg} - (TIME_W+1)'(rem_reg);
                    end
                end
                ST_STEP: begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    cur_reg <= cur_reg + (TIME_W+1)'(w_eff);
                end
                ST_CHECK: begin
                    if (cur_ge_end) begin
                        fin_reg <= 1'b1;
                    end
                end
                ST_SKIPCHK: begin
                    fin_reg <= cur_ge_end;
                end
                default: ;
            endcase
        end
    end

    // payload: sample, staged result, divider, output register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            v_reg <= s_tdata[SAMPLE_W-1:0];
            t_reg <= s_tdata[SAMPLE_W +: TIME_W];
        end
        unique case (state_reg)
            ST_TEST: begin
                diff_reg <= diff_full[TIME_W-1:0];
                nbin_reg <= '0;
            end
            ST_OPEN: begin
                if (diff_ge_w && !cnt_zero) begin
                    // mean of the closing bin
                    dvd_reg       <= TIME_W'(sum_abs) << (TIME_W - SUM_W);
                    dvr_reg       <= DVR_W'(cnt_reg);
                    rem_reg       <= '0;
                    dcnt_reg      <= DCNT_W'(SUM_W);
                    neg_reg       <= sum_reg[SUM_W-1];
                    skip_mode_reg <= 1'b0;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (!skip_mode_reg) begin
                        res_avg_reg <= neg_reg ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);
                    end
                end else begin
                    if (!div_trial[DVR_W+1]) begin
                        rem_reg <= div_trial[DVR_W-1:0];
                        dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= div_shift[DVR_W-1:0];
                        dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                end
            end
            ST_STEP: begin
                res_centre_reg <= cur_reg[TIME_W-1:0] + TIME_W'(half_w);
                res_empty_reg  <= cnt_zero;
                if (cnt_zero) begin
                    res_avg_reg <= '0;
                end
                nbin_reg <= nbin_reg + NBIN_W'(1);
            end
            ST_CHECK: begin
                diff_reg        <= diff_full[TIME_W-1:0];
                res_dropped_reg <= 1'b0;
                if (cur_ge_end) begin
                    res_last_reg <= 1'b1;
                    res_done_reg <= 1'b1;
                end else if (!more_bins) begin
                    res_last_reg <= 1'b1;
                    res_done_reg <= 1'b0;
                end else if (at_bin_limit) begin
                    // remainder of the gap modulo the width locates the bin
                    dvd_reg       <= diff_full[TIME_W-1:0];
                    dvr_reg       <= DVR_W'(w_eff);
                    rem_reg       <= '0;
                    dcnt_reg      <= DCNT_W'(TIME_W);
                    skip_mode_reg <= 1'b1;
                end else begin
                    res_last_reg <= 1'b0;
                    res_done_reg <= 1'b0;
                end
            end
            ST_SKIPCHK: begin
                res_dropped_reg <= 1'b1;
                res_last_reg    <= 1'b1;
                res_done_reg    <= cur_ge_end;
            end
            ST_SEND: begin
                if (out_free) begin
                    m_tdata <= {{(M_TDATA_W - TIME_W - SAMPLE_W){1'b0}},
                                res_avg_reg, res_centre_reg};
                    m_tlast <= res_last_reg;
                    m_tuser <= {res_done_reg, res_dropped_reg, res_empty_reg};
                end
            end
            default: ;
        endcase
    end

endmodule
